// File: sv/visible_text_width_counter_core_assert.svh
// Assertion macros used by the visible text width counter RTL.
`ifndef VISIBLE_TEXT_WIDTH_COUNTER_CORE_ASSERT_SVH
`define VISIBLE_TEXT_WIDTH_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define VTW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtw assertion failed");

// Next-cycle implication, ignored while reset is high.
`define VTW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vtw assertion failed");

`endif

// File: sv/vtw_pkg.sv
// Types and constants for the visible text width counter.
package vtw_pkg;

   // Result count width on the port
   localparam int VIS_WIDTH = 16;

   // Parser modes
   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_PCT    = 3'd1;
   localparam logic [2:0] MODE_PCT_F  = 3'd2;
   localparam logic [2:0] MODE_BRACE  = 3'd3;
   localparam logic [2:0] MODE_ESC    = 3'd4;
   localparam logic [2:0] MODE_CSI    = 3'd5;

   // Byte codes
   localparam logic [7:0] CHR_PCT      = 8'h25;
   localparam logic [7:0] CHR_ESC      = 8'h1B;
   localparam logic [7:0] CHR_UPPER_F  = 8'h46;
   localparam logic [7:0] CHR_LOWER_F  = 8'h66;
   localparam logic [7:0] CHR_LOWER_B  = 8'h62;
   localparam logic [7:0] CHR_UPPER_B  = 8'h42;
   localparam logic [7:0] CHR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHR_LBRACKET = 8'h5B;
   localparam logic [7:0] PRINT_LO     = 8'h20;
   localparam logic [7:0] PRINT_HI     = 8'h7E;
   localparam logic [7:0] CSI_FINAL_LO = 8'h40;
   localparam logic [7:0] CSI_FINAL_HI = 8'h7E;
   localparam logic [1:0] UTF8_LEAD    = 2'b11;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [VIS_WIDTH-1:0] visible_count;
      logic                 count_saturated;
   } rsp_type;

   // One parser step: next mode and how many characters it adds
   typedef struct packed {
      logic [2:0] next_mode;
      logic [1:0] add_amt;
   } step_type;

endpackage

// File: sv/vtw_parse.sv
// Escape-aware parser step: next mode and visible character increment.
module vtw_parse (
   input  logic [2:0]        mode,
   input  logic [7:0]        text_byte,
   input  logic              is_last,
   output vtw_pkg::step_type step
);
   import vtw_pkg::*;

   step_type base;
   step_type core;

   // Classify a byte seen in plain text
   function automatic step_type normal_step(logic [7:0] b);
      step_type s;
      s.next_mode = MODE_NORMAL;
      s.add_amt   = 2'd0;
      if (b == CHR_PCT) begin
         s.next_mode = MODE_PCT;
      end else if (b == CHR_ESC) begin
         s.next_mode = MODE_ESC;
      end else if (b[7:6] == UTF8_LEAD) begin
         s.add_amt = 2'd1;
      end else if (b >= PRINT_LO && b <= PRINT_HI) begin
         s.add_amt = 2'd1;
      end
      return s;
   endfunction

   assign base = normal_step(text_byte);

   // Advance the mode for this byte
   always_comb begin
      core = base;
      unique case (mode)
         MODE_PCT: begin
            if (text_byte == CHR_UPPER_F) begin
               core.next_mode = MODE_PCT_F;
               core.add_amt   = 2'd0;
            end else if (text_byte == CHR_LOWER_F || text_byte == CHR_LOWER_B ||
                         text_byte == CHR_UPPER_B) begin
               core.next_mode = MODE_NORMAL;
               core.add_amt   = 2'd0;
            end else if (text_byte == CHR_PCT) begin
               core.next_mode = MODE_NORMAL;
               core.add_amt   = 2'd1;
            end else begin
               core.add_amt = base.add_amt + 2'd1;
            end
         end
         MODE_PCT_F: begin
            if (text_byte == CHR_LBRACE) begin
               core.next_mode = MODE_BRACE;
               core.add_amt   = 2'd0;
            end else begin
               core.add_amt = base.add_amt + 2'd2;
            end
         end
         MODE_BRACE: begin
            core.add_amt   = 2'd0;
            core.next_mode = (text_byte == CHR_RBRACE) ? MODE_NORMAL : MODE_BRACE;
         end
         MODE_ESC: begin
            if (text_byte == CHR_LBRACKET) begin
               core.next_mode = MODE_CSI;
               core.add_amt   = 2'd0;
            end
         end
         MODE_CSI: begin
            core.add_amt = 2'd0;
            if (text_byte >= CSI_FINAL_LO && text_byte <= CSI_FINAL_HI) begin
               core.next_mode = MODE_NORMAL;
            end else begin
               core.next_mode = MODE_CSI;
            end
         end
         default: begin
            core = base;
         end
      endcase
   end

   // Count a percent or percent-F still pending at the last byte
   always_comb begin
      step = core;
      if (is_last && core.next_mode == MODE_PCT) begin
         step.add_amt = core.add_amt + 2'd1;
      end else if (is_last && core.next_mode == MODE_PCT_F) begin
         step.add_amt = core.add_amt + 2'd2;
      end
   end

endmodule

// File: sv/visible_text_width_counter_core.sv
// Visible text width counter: one string byte per request, count on the last byte.
//
// Input channel req_*: one request per string byte (text_byte, is_last).
// Result channel rsp_*: one response per string, issued for the byte marked
// is_last, carrying the visible character count (low 16 bits) and a flag
// that is set when the internal COUNT_WIDTH-bit counter overflowed and saturated.
// Throughput: one byte per clock unless a last byte waits on a held response;
// the parser step between the input and state/result registers is combinational.
// Result path: a last byte is held in the input register, then its response
// is written to the response register that drives rsp_valid and rsp_data.
// Receiver stall: non-last bytes keep flowing while a response waits; a
// last byte waits in the input register until the response register is
// free, and req_stall rises only then.
// Reset (synchronous, active high): drops buffered requests and responses,
// returns the parser to plain text and clears count and flag. After each
// last byte the same state is restored, so the next byte starts a new string.
`include "visible_text_width_counter_core_assert.svh"

module visible_text_width_counter_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vtw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vtw_pkg::rsp_type rsp_data
);
   import vtw_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   req_type                in_data_ff, in_data_in;
   logic [2:0]             mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                         advance;
   step_type                     step;
   logic [COUNT_WIDTH:0]         sum;
   logic [COUNT_WIDTH-1:0]       count_next;
   logic                         sat_next;
   logic [COUNT_WIDTH+VIS_WIDTH-1:0] count_ext;

   vtw_parse u_parse (
      .mode      (mode_ff),
      .text_byte (in_data_ff.text_byte),
      .is_last   (in_data_ff.is_last),
      .step      (step)
   );

   // Move the buffered request unless it is a last byte blocked by a held response
   assign advance   = in_valid_ff && (!in_data_ff.is_last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Saturating add of this byte's increment
   assign sum        = {1'b0, count_ff} + {{(COUNT_WIDTH - 1){1'b0}}, step.add_amt};
   assign count_next = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
   assign sat_next   = sat_ff | sum[COUNT_WIDTH];
   assign count_ext  = {{VIS_WIDTH{1'b0}}, count_next};

   // Next-state logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop a response once taken
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // capture a new request when the input register frees up
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end

      if (advance) begin
         if (in_data_ff.is_last) begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.visible_count   = count_ext[VIS_WIDTH-1:0];
            rsp_data_in.count_saturated = sat_next;
            mode_in                     = MODE_NORMAL;
            count_in                    = '0;
            sat_in                      = 1'b0;
         end else begin
            mode_in  = step.next_mode;
            count_in = count_next;
            sat_in   = sat_next;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `VTW_ASSERT_NEXT(a_last_gives_rsp, clock, reset, advance && in_data_ff.is_last, rsp_valid_ff)
   `VTW_ASSERT_NEXT(a_last_clears_state, clock, reset, advance && in_data_ff.is_last,
      mode_ff == MODE_NORMAL && count_ff == '0 && !sat_ff)
   `VTW_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
      in_valid_ff && in_data_ff.is_last && rsp_valid_ff && rsp_stall)
   `VTW_ASSERT_NOW(a_sat_at_max, clock, reset, sat_ff, &count_ff)

endmodule
